// ----- src/scha_pkg.sv -----
// shared types, codes and helpers of the size class heap allocator
// used by scha_front, scha_back and the top level; depends on nothing
package scha_pkg;

    // request opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL   = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd2;
    localparam logic [2:0] ST_NO_MEM      = 3'd3;
    localparam logic [2:0] ST_MISMATCH    = 3'd4;
    localparam logic [2:0] ST_DOUBLE_FREE = 3'd5;

    // configuration register indexes
    localparam logic CFG_LEFTOVER    = 1'b0;
    localparam logic CFG_BLOCK_WORDS = 1'b1;

    // tag word flags
    localparam logic [7:0] FL_ALLOC = 8'h01;
    localparam logic [7:0] FL_RIGHT = 8'h02;
    localparam logic [7:0] FL_LEFT  = 8'h04;

    localparam int unsigned MIN_OBJECT  = 4;
    localparam int unsigned TAG_SIZE_W  = 24;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned OBJ_WORDS_W = 13;
    localparam int unsigned ADDR_W      = 16;

    // classified request kinds
    typedef enum logic [2:0] {
        K_NOP   = 3'd0,
        K_ALLOC = 3'd1,
        K_FREE  = 3'd2,
        K_CHECK = 3'd3,
        K_SMALL = 3'd4,
        K_LARGE = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [OBJ_WORDS_W-1:0] n;      // total words incl. both tags
        logic [ADDR_W-1:0]      addr;
    } cmd_t;

    function automatic logic [WORD_W-1:0] make_tag(input logic [TAG_SIZE_W-1:0] size,
                                                   input logic [7:0] flags);
        return {size, flags};
    endfunction

endpackage

// ----- src/scha_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
module scha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- src/scha_front.sv -----
// front end: takes requests, classifies them, holds them in a two entry queue
// depends on scha_pkg
module scha_front #(
    parameter int BUCKETS = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [11:0]         s_payload_words,
    input  logic [15:0]         s_object_address,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output scha_pkg::cmd_t      cmd
);
    import scha_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       in_cmd;
    logic       push, pop;

    // classify
    always_comb begin
        in_cmd.n    = OBJ_WORDS_W'(s_payload_words) + OBJ_WORDS_W'(2);
        in_cmd.addr = s_object_address;
        case (s_opcode)
            OP_ALLOC: begin
                if (in_cmd.n >= OBJ_WORDS_W'(BUCKETS)) begin
                    in_cmd.kind = K_LARGE;
                end else if (in_cmd.n < OBJ_WORDS_W'(MIN_OBJECT)) begin
                    in_cmd.kind = K_SMALL;
                end else begin
                    in_cmd.kind = K_ALLOC;
                end
            end
            OP_FREE:  in_cmd.kind = K_FREE;
            OP_CHECK: in_cmd.kind = K_CHECK;
            default:  in_cmd.kind = K_NOP;
        endcase
    end

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end
endmodule

// ----- src/scha_back.sv -----
// back end: sequencer that carries out one request on arena and bucket memories
// depends on scha_pkg and scha_ram
module scha_back #(
    parameter int BUCKETS     = 256,
    parameter int BLOCK_WORDS = 4096,
    parameter int NUM_BLOCKS  = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  scha_pkg::cmd_t cmd,
    input  logic [7:0]     lt,
    input  logic [12:0]    bwu,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [2:0]     m_status,
    output logic [15:0]    m_granted_address,
    output logic [12:0]    m_granted_words,
    output logic           m_tags_match
);
    import scha_pkg::*;

    localparam int AW    = $clog2(NUM_BLOCKS * BLOCK_WORDS);
    localparam int BIW   = $clog2(BUCKETS);
    localparam int TW0   = $clog2(BLOCK_WORDS + 1);
    localparam int TW    = (TW0 > 13) ? TW0 : 13;
    localparam int NBW   = $clog2(NUM_BLOCKS + 1);
    localparam int CNTW  = $clog2(BIW);
    localparam logic [BIW-1:0] DIVIDEND = BIW'(BUCKETS - 1);
    localparam logic [BIW-1:0] TOP_IDX  = BIW'(BUCKETS - 1);

    typedef enum logic [17:0] {
        S_IDLE       = 18'h00001,
        S_DECODE     = 18'h00002,
        S_FR_TAIL_RD = 18'h00004,
        S_FR_CHECK   = 18'h00008,
        S_UL_HEAD    = 18'h00010,
        S_UL_NEXT    = 18'h00020,
        S_DIV        = 18'h00040,
        S_MUL        = 18'h00080,
        S_KCHK       = 18'h00100,
        S_OLD        = 18'h00200,
        S_BUMP       = 18'h00400,
        S_NEWBLK     = 18'h00800,
        S_WR_HEAD    = 18'h01000,
        S_WR_TAIL    = 18'h02000,
        S_LK_RD      = 18'h04000,
        S_LK_WR      = 18'h08000,
        S_DONE       = 18'h10000
    } state_t;

    typedef enum logic [1:0] {
        AFT_DONE  = 2'd0,
        AFT_LINK  = 2'd1,
        AFT_SPLIT = 2'd2
    } after_t;

    state_t               state_reg, state_next;
    after_t               after_reg, after_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [BIW-1:0]       bfs_reg, bfs_next;
    logic                 cbv_reg, cbv_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [TW-1:0]        top_reg, top_next;
    logic [NBW-1:0]       nbi_reg, nbi_next;
    logic [BUCKETS-1:0]   bvalid_reg, bvalid_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [BIW-1:0]       usz_reg, usz_next;
    logic                 big_reg, big_next;
    logic [WORD_W-1:0]    ftag_reg, ftag_next;
    logic [AW-1:0]        whead_reg, whead_next;
    logic [TAG_SIZE_W-1:0] wsz_reg, wsz_next;
    logic [WORD_W-1:0]    wtag_reg, wtag_next;
    logic [AW-1:0]        lh_reg, lh_next;
    logic [BIW-1:0]       lsz_reg, lsz_next;
    logic [WORD_W-1:0]    spl_tag_reg, spl_tag_next;
    logic                 newp_reg, newp_next;
    logic [BIW:0]         div_rem_reg, div_rem_next;
    logic [BIW-1:0]       div_q_reg, div_q_next;
    logic [CNTW-1:0]      div_cnt_reg, div_cnt_next;
    logic [BIW-1:0]       k_reg, k_next;
    logic [2:0]           res_status_reg, res_status_next;
    logic [15:0]          res_addr_reg, res_addr_next;
    logic [12:0]          res_words_reg, res_words_next;
    logic                 res_match_reg, res_match_next;
    logic                 m_valid_reg, m_valid_next;
    logic [2:0]           m_status_reg, m_status_next;
    logic [15:0]          m_addr_reg, m_addr_next;
    logic [12:0]          m_words_reg, m_words_next;
    logic                 m_match_reg, m_match_next;

    // memory ports
    logic              ar_we, ar_re;
    logic [AW-1:0]     ar_waddr, ar_raddr;
    logic [WORD_W-1:0] ar_wdata, ar_rdata;
    logic              bh_we, bh_re;
    logic [BIW-1:0]    bh_waddr, bh_raddr;
    logic [AW-1:0]     bh_wdata, bh_rdata;

    // helpers
    logic [BIW-1:0]    nb, diff, up_idx, dn_idx;
    logic [TW-1:0]     n_t, bwu_ext, bs, space, left;
    logic [BIW:0]      trial;
    logic [AW-1:0]     f_head, tail_addr, cur_head;
    logic              c_top, c_up, c_dn;

    assign nb        = cmd_reg.n[BIW-1:0];
    assign n_t       = TW'(nb);
    assign bwu_ext   = TW'(bwu);
    assign bs        = (bwu_ext < TW'(BLOCK_WORDS)) ? bwu_ext : TW'(BLOCK_WORDS);
    assign space     = (bs > top_reg) ? bs - top_reg : '0;
    assign left      = space - n_t;
    assign diff      = usz_reg - nb;
    assign up_idx    = usz_reg + BIW'(1);
    assign dn_idx    = usz_reg - BIW'(1);
    assign trial     = {div_rem_reg[BIW-1:0], DIVIDEND[div_cnt_reg]};
    assign f_head    = AW'(cmd_reg.addr) - AW'(1);
    assign tail_addr = whead_reg + AW'(wsz_reg) - AW'(1);
    assign cur_head  = base_reg + AW'(top_reg);
    // replacement candidates once the bucket of usz has just gone empty
    assign c_top     = bvalid_reg[TOP_IDX] && (usz_reg != TOP_IDX);
    assign c_up      = (usz_reg < TOP_IDX) && bvalid_reg[up_idx];
    assign c_dn      = (usz_reg != '0) && bvalid_reg[dn_idx];

    scha_ram #(.WIDTH(WORD_W), .DEPTH(1 << AW)) u_arena (
        .aclk  (aclk),
        .we    (ar_we),
        .waddr (ar_waddr),
        .wdata (ar_wdata),
        .re    (ar_re),
        .raddr (ar_raddr),
        .rdata (ar_rdata)
    );

    scha_ram #(.WIDTH(AW), .DEPTH(BUCKETS)) u_heads (
        .aclk  (aclk),
        .we    (bh_we),
        .waddr (bh_waddr),
        .wdata (bh_wdata),
        .re    (bh_re),
        .raddr (bh_raddr),
        .rdata (bh_rdata)
    );

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        after_next      = after_reg;
        cmd_next        = cmd_reg;
        bfs_next        = bfs_reg;
        cbv_next        = cbv_reg;
        base_next       = base_reg;
        top_next        = top_reg;
        nbi_next        = nbi_reg;
        bvalid_next     = bvalid_reg;
        head_next       = head_reg;
        usz_next        = usz_reg;
        big_next        = big_reg;
        ftag_next       = ftag_reg;
        whead_next      = whead_reg;
        wsz_next        = wsz_reg;
        wtag_next       = wtag_reg;
        lh_next         = lh_reg;
        lsz_next        = lsz_reg;
        spl_tag_next    = spl_tag_reg;
        newp_next       = newp_reg;
        div_rem_next    = div_rem_reg;
        div_q_next      = div_q_reg;
        div_cnt_next    = div_cnt_reg;
        k_next          = k_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_words_next  = res_words_reg;
        res_match_next  = res_match_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        m_words_next    = m_words_reg;
        m_match_next    = m_match_reg;
        ar_we    = 1'b0;
        ar_waddr = whead_reg;
        ar_wdata = wtag_reg;
        ar_re    = 1'b0;
        ar_raddr = f_head;
        bh_we    = 1'b0;
        bh_waddr = usz_reg;
        bh_wdata = bh_rdata;
        bh_re    = 1'b0;
        bh_raddr = usz_reg;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_next   = cmd;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_status_next = ST_OK;
                res_addr_next   = '0;
                res_words_next  = '0;
                res_match_next  = 1'b0;
                case (cmd_reg.kind)
                    K_ALLOC: begin
                        if (bvalid_reg[nb]) begin
                            usz_next   = nb;
                            big_next   = 1'b0;
                            bh_re      = 1'b1;
                            bh_raddr   = nb;
                            state_next = S_UL_HEAD;
                        end else if (bfs_reg > nb && bvalid_reg[bfs_reg]) begin
                            usz_next   = bfs_reg;
                            big_next   = 1'b1;
                            bh_re      = 1'b1;
                            bh_raddr   = bfs_reg;
                            state_next = S_UL_HEAD;
                        end else begin
                            state_next = S_BUMP;
                        end
                    end
                    K_FREE, K_CHECK: begin
                        ar_re      = 1'b1;
                        ar_raddr   = f_head;
                        state_next = S_FR_TAIL_RD;
                    end
                    K_SMALL: begin
                        res_status_next = ST_TOO_SMALL;
                        state_next      = S_DONE;
                    end
                    K_LARGE: begin
                        res_status_next = ST_TOO_LARGE;
                        state_next      = S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_FR_TAIL_RD: begin
                ftag_next  = ar_rdata;
                ar_re      = 1'b1;
                ar_raddr   = f_head + AW'(ar_rdata[WORD_W-1:8]) - AW'(1);
                state_next = S_FR_CHECK;
            end
            S_FR_CHECK: begin
                res_match_next = (ar_rdata == ftag_reg);
                state_next     = S_DONE;
                if (cmd_reg.kind == K_FREE) begin
                    if (ar_rdata != ftag_reg) begin
                        res_status_next = ST_MISMATCH;
                    end else if ((ftag_reg[7:0] & FL_ALLOC) == 8'h00) begin
                        res_status_next = ST_DOUBLE_FREE;
                    end else if (ftag_reg[WORD_W-1:8] < TAG_SIZE_W'(MIN_OBJECT)) begin
                        res_status_next = ST_TOO_SMALL;
                    end else if (ftag_reg[WORD_W-1:8] >= TAG_SIZE_W'(BUCKETS)) begin
                        res_status_next = ST_TOO_LARGE;
                    end else begin
                        whead_next = f_head;
                        wsz_next   = ftag_reg[WORD_W-1:8];
                        wtag_next  = ftag_reg & ~WORD_W'(FL_ALLOC);
                        lh_next    = f_head;
                        lsz_next   = ftag_reg[BIW+7:8];
                        newp_next  = 1'b0;
                        after_next = AFT_LINK;
                        state_next = S_WR_HEAD;
                    end
                end
            end
            S_UL_HEAD: begin
                head_next  = bh_rdata;
                ar_re      = 1'b1;
                ar_raddr   = bh_rdata + AW'(1);
                state_next = S_UL_NEXT;
            end
            S_UL_NEXT: begin
                ar_re      = 1'b1;
                ar_raddr   = head_reg;
                state_next = S_OLD;
                if (ar_rdata[WORD_W-1]) begin
                    bh_we    = 1'b1;
                    bh_waddr = usz_reg;
                    bh_wdata = ar_rdata[AW-1:0];
                end else begin
                    bvalid_next[usz_reg] = 1'b0;
                    if (bfs_reg == usz_reg) begin
                        if (c_top) begin
                            bfs_next = TOP_IDX;
                        end else if (c_up) begin
                            bfs_next = up_idx;
                        end else if (c_dn) begin
                            bfs_next = dn_idx;
                        end else begin
                            div_rem_next = '0;
                            div_q_next   = '0;
                            div_cnt_next = CNTW'(BIW - 1);
                            state_next   = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                if (trial >= {1'b0, usz_reg}) begin
                    div_rem_next = trial - {1'b0, usz_reg};
                    div_q_next   = {div_q_reg[BIW-2:0], 1'b1};
                end else begin
                    div_rem_next = trial;
                    div_q_next   = {div_q_reg[BIW-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - CNTW'(1);
                if (div_cnt_reg == '0) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                k_next     = BIW'(div_q_reg * usz_reg);
                state_next = S_KCHK;
            end
            S_KCHK: begin
                bfs_next   = (bvalid_reg[k_reg] && k_reg != usz_reg) ? k_reg : '0;
                state_next = S_OLD;
            end
            S_OLD: begin
                whead_next     = head_reg;
                res_addr_next  = 16'(32'(head_reg) + 32'd1);
                after_next     = AFT_DONE;
                state_next     = S_WR_HEAD;
                if (!big_reg) begin
                    wsz_next       = TAG_SIZE_W'(nb);
                    wtag_next      = make_tag(TAG_SIZE_W'(nb), ar_rdata[7:0] | FL_ALLOC);
                    res_words_next = 13'(nb);
                end else if (13'(diff) < 13'(lt) || diff < BIW'(MIN_OBJECT)) begin
                    wsz_next       = TAG_SIZE_W'(usz_reg);
                    wtag_next      = make_tag(TAG_SIZE_W'(usz_reg), ar_rdata[7:0] | FL_ALLOC);
                    res_words_next = 13'(usz_reg);
                end else begin
                    wsz_next       = TAG_SIZE_W'(nb);
                    wtag_next      = make_tag(TAG_SIZE_W'(nb),
                                              (ar_rdata[7:0] & FL_LEFT) | FL_RIGHT | FL_ALLOC);
                    res_words_next = 13'(nb);
                    lh_next        = head_reg + AW'(nb);
                    lsz_next       = diff;
                    spl_tag_next   = make_tag(TAG_SIZE_W'(diff),
                                              FL_LEFT | (ar_rdata[7:0] & FL_RIGHT));
                    newp_next      = 1'b0;
                    after_next     = AFT_SPLIT;
                end
            end
            S_BUMP: begin
                if (cbv_reg && n_t <= space) begin
                    whead_next    = cur_head;
                    res_addr_next = 16'(32'(cur_head) + 32'd1);
                    after_next    = AFT_DONE;
                    state_next    = S_WR_HEAD;
                    if (left <= TW'(lt)) begin
                        // close the block, the tail goes to this object
                        wsz_next       = TAG_SIZE_W'(space);
                        wtag_next      = make_tag(TAG_SIZE_W'(space), FL_LEFT | FL_ALLOC);
                        res_words_next = 13'(space);
                        cbv_next       = 1'b0;
                        top_next       = '0;
                    end else begin
                        wsz_next       = TAG_SIZE_W'(n_t);
                        wtag_next      = make_tag(TAG_SIZE_W'(n_t),
                                                  FL_LEFT | FL_RIGHT | FL_ALLOC);
                        res_words_next = 13'(n_t);
                        top_next       = top_reg + n_t;
                    end
                end else if (nbi_reg >= NBW'(NUM_BLOCKS) || n_t > bs) begin
                    res_status_next = ST_NO_MEM;
                    state_next      = S_DONE;
                end else if (cbv_reg && space >= TW'(MIN_OBJECT)) begin
                    // free the old block's tail before opening a new one
                    whead_next = cur_head;
                    wsz_next   = TAG_SIZE_W'(space);
                    wtag_next  = make_tag(TAG_SIZE_W'(space), FL_LEFT);
                    lh_next    = cur_head;
                    lsz_next   = BIW'(space);
                    newp_next  = 1'b1;
                    after_next = AFT_LINK;
                    state_next = S_WR_HEAD;
                end else begin
                    state_next = S_NEWBLK;
                end
            end
            S_NEWBLK: begin
                base_next      = AW'(32'(nbi_reg) * BLOCK_WORDS);
                nbi_next       = nbi_reg + NBW'(1);
                cbv_next       = 1'b1;
                top_next       = n_t;
                whead_next     = AW'(32'(nbi_reg) * BLOCK_WORDS);
                wsz_next       = TAG_SIZE_W'(n_t);
                wtag_next      = make_tag(TAG_SIZE_W'(n_t), FL_RIGHT | FL_ALLOC);
                res_addr_next  = 16'(32'(nbi_reg) * BLOCK_WORDS + 1);
                res_words_next = 13'(n_t);
                newp_next      = 1'b0;
                after_next     = AFT_DONE;
                state_next     = S_WR_HEAD;
            end
            S_WR_HEAD: begin
                ar_we      = 1'b1;
                ar_waddr   = whead_reg;
                ar_wdata   = wtag_reg;
                state_next = S_WR_TAIL;
            end
            S_WR_TAIL: begin
                ar_we    = 1'b1;
                ar_waddr = tail_addr;
                ar_wdata = wtag_reg;
                case (after_reg)
                    AFT_LINK:  state_next = S_LK_RD;
                    AFT_SPLIT: begin
                        whead_next = lh_reg;
                        wsz_next   = TAG_SIZE_W'(lsz_reg);
                        wtag_next  = spl_tag_reg;
                        after_next = AFT_LINK;
                        state_next = S_WR_HEAD;
                    end
                    default:   state_next = S_DONE;
                endcase
            end
            S_LK_RD: begin
                bh_re      = 1'b1;
                bh_raddr   = lsz_reg;
                state_next = S_LK_WR;
            end
            S_LK_WR: begin
                ar_we    = 1'b1;
                ar_waddr = lh_reg + AW'(1);
                ar_wdata = bvalid_reg[lsz_reg] ? ({1'b1, (WORD_W - 1)'(0)} | WORD_W'(bh_rdata))
                                               : '0;
                bh_we    = 1'b1;
                bh_waddr = lsz_reg;
                bh_wdata = lh_reg;
                bvalid_next[lsz_reg] = 1'b1;
                if (lsz_reg > bfs_reg) begin
                    bfs_next = lsz_reg;
                end
                state_next = newp_reg ? S_NEWBLK : S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = (cmd_reg.kind == K_ALLOC && res_status_reg == ST_OK)
                                    ? res_addr_reg : '0;
                    m_words_next  = (cmd_reg.kind == K_ALLOC && res_status_reg == ST_OK)
                                    ? res_words_reg : '0;
                    m_match_next  = res_match_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            bfs_reg     <= '0;
            cbv_reg     <= 1'b0;
            base_reg    <= '0;
            top_reg     <= '0;
            nbi_reg     <= '0;
            bvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bfs_reg     <= bfs_next;
            cbv_reg     <= cbv_next;
            base_reg    <= base_next;
            top_reg     <= top_next;
            nbi_reg     <= nbi_next;
            bvalid_reg  <= bvalid_next;
            m_valid_reg <= m_valid_next;
        end
        after_reg      <= after_next;
        cmd_reg        <= cmd_next;
        head_reg       <= head_next;
        usz_reg        <= usz_next;
        big_reg        <= big_next;
        ftag_reg       <= ftag_next;
        whead_reg      <= whead_next;
        wsz_reg        <= wsz_next;
        wtag_reg       <= wtag_next;
        lh_reg         <= lh_next;
        lsz_reg        <= lsz_next;
        spl_tag_reg    <= spl_tag_next;
        newp_reg       <= newp_next;
        div_rem_reg    <= div_rem_next;
        div_q_reg      <= div_q_next;
        div_cnt_reg    <= div_cnt_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_words_reg  <= res_words_next;
        res_match_reg  <= res_match_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
        m_words_reg    <= m_words_next;
        m_match_reg    <= m_match_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_granted_address = m_addr_reg;
    assign m_granted_words   = m_words_reg;
    assign m_tags_match      = m_match_reg;

    // a popped command always goes to decode next
    a_pop_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && cmd_ready |=> state_reg == S_DECODE)
        else $error("popped command not decoded");

    // the multiply step only follows the divider
    a_mul_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL |-> $past(state_reg) == S_DIV)
        else $error("multiply without division");

    // a finished request always lands in the output register
    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && (!m_valid_reg || m_ready) |=> m_valid_reg)
        else $error("result lost");

    // failed results never carry a grant
    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != ST_OK |-> m_addr_reg == '0 && m_words_reg == '0)
        else $error("grant on failure");
endmodule

// ----- src/size_class_heap_allocator.sv -----
// size class heap allocator with boundary tags: top level
// depends on scha_pkg, scha_front, scha_back (which holds the scha_ram instances)
// the back end sequencer serves one request at a time and takes no new request before
// the last one has reached the result register
// reset is synchronous active low; bucket valid bits clear at once, arena holds garbage
module size_class_heap_allocator #(
    parameter int BUCKETS     = 256,
    parameter int BLOCK_WORDS = 4096,
    parameter int NUM_BLOCKS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [11:0] s_payload_words,
    input  logic [15:0] s_object_address,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_granted_address,
    output logic [12:0] m_granted_words,
    output logic        m_tags_match,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);
    import scha_pkg::*;

    // configuration registers, read live by the back end
    logic [7:0]  lt_reg, lt_next;
    logic [12:0] bwu_reg, bwu_next;

    // front to back command transaction
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        lt_next  = lt_reg;
        bwu_next = bwu_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_LEFTOVER:    lt_next  = cfg_data[7:0];
                CFG_BLOCK_WORDS: bwu_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lt_reg  <= 8'd8;
            bwu_reg <= 13'd4000;
        end else begin
            lt_reg  <= lt_next;
            bwu_reg <= bwu_next;
        end
    end

    // front end: classify and queue requests
    scha_front #(.BUCKETS(BUCKETS)) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_payload_words  (s_payload_words),
        .s_object_address (s_object_address),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .cmd              (cmd)
    );

    // back end: memory sequencer and result register
    scha_back #(
        .BUCKETS     (BUCKETS),
        .BLOCK_WORDS (BLOCK_WORDS),
        .NUM_BLOCKS  (NUM_BLOCKS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd_valid         (cmd_valid),
        .cmd_ready         (cmd_ready),
        .cmd               (cmd),
        .lt                (lt_reg),
        .bwu               (bwu_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_address (m_granted_address),
        .m_granted_words   (m_granted_words),
        .m_tags_match      (m_tags_match)
    );
endmodule
